### design/dpfs_pkg.sv
// Shared types, codes and constants of the doubled pixel frame store.
package dpfs_pkg;

   localparam int COL_W   = 6;
   localparam int ROW_W   = 5;
   localparam int BAND_W  = 3;
   localparam int BIT_W   = 2;
   localparam int ENTRY_W = 4;
   localparam int BYTE_W  = 8;
   localparam int IDX_W   = 9;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_DRAW  = 1'b1;

   localparam logic KIND_CMD  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   localparam logic [BYTE_W-1:0] COL_CMD_BASE  = 8'h80;
   localparam logic [BYTE_W-1:0] BANK_CMD_BASE = 8'h40;

   localparam logic [BYTE_W-1:0] PAIR_0 = 8'h03;
   localparam logic [BYTE_W-1:0] PAIR_1 = 8'h0C;
   localparam logic [BYTE_W-1:0] PAIR_2 = 8'h30;
   localparam logic [BYTE_W-1:0] PAIR_3 = 8'hC0;

   function automatic logic [BYTE_W-1:0] widen_band(input logic [ENTRY_W-1:0] nib);
      logic [BYTE_W-1:0] b;
      b = '0;
      if (nib[0]) b = b | PAIR_0;
      if (nib[1]) b = b | PAIR_1;
      if (nib[2]) b = b | PAIR_2;
      if (nib[3]) b = b | PAIR_3;
      return b;
   endfunction

endpackage

### design/dpfs_if.sv
// Valid/ready channels for pixel requests and display words.
interface dpfs_req_if
   import dpfs_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;
   logic             pixel_on;

   modport source (output valid, cmd, col, row, pixel_on, input ready);
   modport sink   (input valid, cmd, col, row, pixel_on, output ready);
endinterface

interface dpfs_rsp_if
   import dpfs_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              is_data;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, is_data, out_byte, last, input ready);
   modport sink   (input valid, is_data, out_byte, last, output ready);
endinterface

### design/doubled_pixel_frame_store_core.sv
// Top level of the doubled pixel frame store: band memory, sequencer and word output.
//
// req_ch carries one request word: cmd (write or draw), col, row and pixel_on.
// rsp_ch carries display words: is_data, out_byte and last.
// A write sets or clears one pixel and returns nothing.
// A draw returns six words for the band holding the pixel: column command,
// bank command and doubled data byte for display column 2*col, then the same
// for 2*col+1, with last on the sixth word. A draw passes through the read
// state before the first word, then gives one word per cycle while
// rsp_ch.ready is high. Requests outside the grid are taken and dropped.
// The block holds one request at a time: req_ch.ready is high only while no
// request is in flight. Each request goes through the registered read of the
// band memory, followed by the read-modify-write or the six-word sequence.
// When the receiver holds rsp_ch.ready low, the current word stays on the
// port unchanged. Reset clears all valid bits of the band memory, so every
// pixel reads as clear at once; no clearing pass is needed.
module doubled_pixel_frame_store_core
   import dpfs_pkg::*;
#(
   parameter int GRID_COLS = 42,
   parameter int GRID_ROWS = 24
) (
   input  logic       clock,
   input  logic       reset,
   dpfs_req_if.sink   req_ch,
   dpfs_rsp_if.source rsp_ch
);

   localparam int BAND_COUNT = (GRID_ROWS + 3) / 4;
   localparam int DEPTH      = GRID_COLS * BAND_COUNT;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [COL_W:0] COL_LIMIT = (COL_W + 1)'(GRID_COLS);
   localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W + 1)'(GRID_ROWS);
   localparam logic [2:0] STEP_LAST = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [2:0]           step_ff, step_in;
   logic [DEPTH-1:0]     vld_ff;

   logic                 cmd_ff;
   logic [COL_W-1:0]     col_ff;
   logic [BAND_W-1:0]    band_ff;
   logic [BIT_W-1:0]     bit_ff;
   logic                 on_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [BYTE_W-1:0]    data_ff;
   logic [ENTRY_W-1:0]   rd_data_ff;
   logic                 rd_vld_ff;

   logic [ENTRY_W-1:0]   mem [DEPTH];

   logic                 accept;
   logic                 in_range;
   logic [BAND_W-1:0]    req_band;
   logic [IDX_W-1:0]     idx_wide;
   logic [ADDR_W-1:0]    req_addr;
   logic [ENTRY_W-1:0]   entry;
   logic [ENTRY_W-1:0]   bit_mask;
   logic [ENTRY_W-1:0]   new_entry;
   logic                 mem_we;
   logic                 resp_take;
   logic [BYTE_W-1:0]    col_byte;
   logic [BYTE_W-1:0]    bank_byte;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_range     = ({1'b0, req_ch.col} < COL_LIMIT) && ({1'b0, req_ch.row} < ROW_LIMIT);
   assign req_band     = req_ch.row[ROW_W-1:BIT_W];
   assign idx_wide     = IDX_W'(req_ch.col) * IDX_W'(BAND_COUNT) + IDX_W'(req_band);
   assign req_addr     = idx_wide[ADDR_W-1:0];

   assign entry     = rd_vld_ff ? rd_data_ff : '0;
   assign bit_mask  = ENTRY_W'(1) << bit_ff;
   assign new_entry = on_ff ? (entry | bit_mask) : (entry & ~bit_mask);
   assign mem_we    = (state_ff == ST_READ) && (cmd_ff == CMD_WRITE);
   assign resp_take = rsp_ch.valid && rsp_ch.ready;

   assign col_byte  = COL_CMD_BASE | {1'b0, col_ff, 1'b0};
   assign bank_byte = BANK_CMD_BASE | BYTE_W'(band_ff);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept && in_range) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = (cmd_ff == CMD_DRAW) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (resp_take) begin
               step_in = step_ff + 3'd1;
               if (step_ff == STEP_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= new_entry;
      end
      if (accept) begin
         rd_data_ff <= mem[req_addr];
         rd_vld_ff  <= vld_ff[req_addr];
         cmd_ff     <= req_ch.cmd;
         col_ff     <= req_ch.col;
         band_ff    <= req_band;
         bit_ff     <= req_ch.row[BIT_W-1:0];
         on_ff      <= req_ch.pixel_on;
         addr_ff    <= req_addr;
      end
      if (state_ff == ST_READ) begin
         data_ff <= widen_band(entry);
      end
   end

   always_comb begin
      rsp_ch.valid    = (state_ff == ST_EMIT);
      rsp_ch.is_data  = KIND_CMD;
      rsp_ch.out_byte = col_byte;
      rsp_ch.last     = 1'b0;
      case (step_ff)
         3'd0: begin
            rsp_ch.out_byte = col_byte;
         end
         3'd1, 3'd4: begin
            rsp_ch.out_byte = bank_byte;
         end
         3'd2: begin
            rsp_ch.is_data  = KIND_DATA;
            rsp_ch.out_byte = data_ff;
         end
         3'd3: begin
            rsp_ch.out_byte = col_byte | 8'h01;
         end
         3'd5: begin
            rsp_ch.is_data  = KIND_DATA;
            rsp_ch.out_byte = data_ff;
            rsp_ch.last     = 1'b1;
         end
         default: begin
            rsp_ch.out_byte = col_byte;
         end
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_ch.valid && req_ch.ready))
      else $error("request taken while words are pending");

   a_drop_range: assert property (@(posedge clock) disable iff (reset)
      (accept && !in_range) |=> (req_ch.ready && !rsp_ch.valid))
      else $error("out-of-grid request not dropped");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (resp_take && rsp_ch.last) |=> !rsp_ch.valid)
      else $error("words continue after last");

   a_data_doubled: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.is_data) |->
         ((rsp_ch.out_byte[0] == rsp_ch.out_byte[1]) &&
          (rsp_ch.out_byte[2] == rsp_ch.out_byte[3]) &&
          (rsp_ch.out_byte[4] == rsp_ch.out_byte[5]) &&
          (rsp_ch.out_byte[6] == rsp_ch.out_byte[7])))
      else $error("data byte not vertically doubled");

endmodule
